>>> hw/rtl/mle3d_pkg.sv
// ----------------------------------------------------------------------------
// mle3d_pkg
// Shared types and constants for the masked Laplacian energy unit: payload
// words, register indexes, axis codes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package mle3d_pkg;

   localparam int SAMPLE_W = 16;
   localparam int ENTRY_W  = SAMPLE_W + 1;
   localparam int DIFF_W   = 19;
   localparam int SQ_W     = 35;
   localparam int SUM_W    = 60;
   localparam int MEAN_W   = 36;
   localparam int CSR_W    = 9;
   localparam int CSR_IW   = 2;
   localparam int STEP_W   = $clog2(SUM_W);

   // register indexes
   localparam logic [CSR_IW-1:0] REG_SIZE_X = 2'd0;
   localparam logic [CSR_IW-1:0] REG_SIZE_Y = 2'd1;
   localparam logic [CSR_IW-1:0] REG_SIZE_Z = 2'd2;

   // axis codes, AXIS_END closes the per-voxel axis walk
   localparam logic [1:0] AXIS_X   = 2'd0;
   localparam logic [1:0] AXIS_Y   = 2'd1;
   localparam logic [1:0] AXIS_Z   = 2'd2;
   localparam logic [1:0] AXIS_END = 2'd3;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       known;
   } req_type;

   typedef struct packed {
      logic [SUM_W-1:0]  energy_sum;
      logic [MEAN_W-1:0] energy_mean;
   } rsp_type;

   typedef struct packed {
      logic       accept;
      logic [1:0] axis;
      logic       lo;
      logic       take_c;
      logic       take_l;
      logic       diff;
      logic       square;
      logic       add;
      logic       write;
      logic       advance;
      logic       cnt1;
      logic       cnt2;
      logic       div_start;
      logic       div_step;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic [2:0] axis_ok;
      logic       last;
      logic       div_done;
      logic       out_free;
   } sts_type;

endpackage

>>> hw/rtl/masked_laplacian_energy_3d_unit.sv
// ----------------------------------------------------------------------------
// masked_laplacian_energy_3d_unit
// Streams voxels in raster order and returns the summed squared second
// differences of unmasked voxels, with the mean over the volume.
//
//   channel  ports                        word
//   input    req_valid/req_stall/req_data  one voxel {sample, known}
//   result   rsp_valid/rsp_stall/rsp_data  {energy_sum, energy_mean}
//   config   csr_we/csr_index/csr_wdata    size_x, size_y, size_z
//
// Each voxel runs the read, difference, square and add steps once for
// each axis on which it is interior; one read port of the plane store
// serves all reads. The last voxel of a volume also runs the count and
// the bit-serial 60-step divider. Reset is synchronous; no clearing pass.
// A held result stalls only the next end of volume.
// ----------------------------------------------------------------------------
module masked_laplacian_energy_3d_unit
   import mle3d_pkg::*;
#(
   parameter int MAX_X = 256,
   parameter int MAX_Y = 256,
   parameter int MAX_Z = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_data,
   input  logic              csr_we,
   input  logic [CSR_IW-1:0] csr_index,
   input  logic [CSR_W-1:0]  csr_wdata
);

   cmd_type cmd;
   sts_type sts;

   mle3d_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   mle3d_dp #(
      .MAX_X (MAX_X),
      .MAX_Y (MAX_Y),
      .MAX_Z (MAX_Z)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

>>> hw/rtl/mle3d_ram.sv
// ----------------------------------------------------------------------------
// mle3d_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module mle3d_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 131072
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and read, read data registered
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/mle3d_ctrl.sv
// ----------------------------------------------------------------------------
// mle3d_ctrl
// Sequencer for the energy unit: walks the three axes of each voxel, writes
// the voxel to the plane store, and at the end of a volume runs the count
// and the divider before loading the result word.
// ----------------------------------------------------------------------------
module mle3d_ctrl
   import mle3d_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [14:0] {
      ST_IDLE    = 15'b000000000000001,
      ST_NEXT    = 15'b000000000000010,
      ST_RD_C    = 15'b000000000000100,
      ST_RD_L    = 15'b000000000001000,
      ST_TAKE_L  = 15'b000000000010000,
      ST_DIFF    = 15'b000000000100000,
      ST_SQUARE  = 15'b000000001000000,
      ST_ADD     = 15'b000000010000000,
      ST_WRITE   = 15'b000000100000000,
      ST_ADVANCE = 15'b000001000000000,
      ST_COUNT1  = 15'b000010000000000,
      ST_COUNT2  = 15'b000100000000000,
      ST_DIVINIT = 15'b001000000000000,
      ST_DIV     = 15'b010000000000000,
      ST_OUT     = 15'b100000000000000
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] axis_ff, axis_in;
   logic       axis_ok;

   // pick the interior flag of the current axis
   always_comb begin
      case (axis_ff)
         AXIS_X:  axis_ok = sts.axis_ok[0];
         AXIS_Y:  axis_ok = sts.axis_ok[1];
         AXIS_Z:  axis_ok = sts.axis_ok[2];
         default: axis_ok = 1'b0;
      endcase
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      cmd      = '0;
      cmd.axis = axis_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               axis_in    = AXIS_X;
               state_in   = ST_NEXT;
            end
         end
         ST_NEXT: begin
            if (axis_ff == AXIS_END) begin
               state_in = ST_WRITE;
            end else if (axis_ok) begin
               state_in = ST_RD_C;
            end else begin
               axis_in = axis_ff + 2'd1;
            end
         end
         ST_RD_C: begin
            state_in = ST_RD_L;
         end
         ST_RD_L: begin
            cmd.lo     = 1'b1;
            cmd.take_c = 1'b1;
            state_in   = ST_TAKE_L;
         end
         ST_TAKE_L: begin
            cmd.take_l = 1'b1;
            state_in   = ST_DIFF;
         end
         ST_DIFF: begin
            cmd.diff = 1'b1;
            state_in = ST_SQUARE;
         end
         ST_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = ST_ADD;
         end
         ST_ADD: begin
            cmd.add  = 1'b1;
            axis_in  = axis_ff + 2'd1;
            state_in = ST_NEXT;
         end
         ST_WRITE: begin
            cmd.write = 1'b1;
            state_in  = ST_ADVANCE;
         end
         ST_ADVANCE: begin
            cmd.advance = 1'b1;
            state_in    = sts.last ? ST_COUNT1 : ST_IDLE;
         end
         ST_COUNT1: begin
            cmd.cnt1 = 1'b1;
            state_in = ST_COUNT2;
         end
         ST_COUNT2: begin
            cmd.cnt2 = 1'b1;
            state_in = ST_DIVINIT;
         end
         ST_DIVINIT: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         axis_ff  <= AXIS_X;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

>>> hw/rtl/mle3d_dp.sv
// ----------------------------------------------------------------------------
// mle3d_dp
// Datapath of the energy unit: size registers, raster position, plane store
// addressing, second difference and square, accumulator, voxel count,
// restoring divider and the result register.
// ----------------------------------------------------------------------------
module mle3d_dp
   import mle3d_pkg::*;
#(
   parameter int MAX_X = 256,
   parameter int MAX_Y = 256,
   parameter int MAX_Z = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  req_type           req_data,
   input  logic              rsp_stall,
   output logic              rsp_valid,
   output rsp_type           rsp_data,
   input  logic              csr_we,
   input  logic [CSR_IW-1:0] csr_index,
   input  logic [CSR_W-1:0]  csr_wdata,
   input  cmd_type           cmd,
   output sts_type           sts
);

   localparam int XW    = $clog2(MAX_X);
   localparam int YW    = $clog2(MAX_Y);
   localparam int ZW    = $clog2(MAX_Z);
   localparam int SXW   = $clog2(MAX_X + 1);
   localparam int SYW   = $clog2(MAX_Y + 1);
   localparam int SZW   = $clog2(MAX_Z + 1);
   localparam int PLANE = MAX_X * MAX_Y;
   localparam int DEPTH = 2 * PLANE;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = SXW + SYW + SZW;

   logic [SXW-1:0] size_x_ff, size_x_in;
   logic [SYW-1:0] size_y_ff, size_y_in;
   logic [SZW-1:0] size_z_ff, size_z_in;
   logic [XW-1:0]  x_ff, x_in;
   logic [YW-1:0]  y_ff, y_in;
   logic [ZW-1:0]  z_ff, z_in;
   logic [SUM_W-1:0] acc_ff, acc_in;
   logic [ENTRY_W-1:0] cur_ff, cent_ff, lo_ff;
   logic signed [DIFF_W-1:0] d_ff;
   logic [SQ_W-1:0]  sq_ff;
   logic [CW-1:0]    cnt_ff;
   logic [CW:0]      rem_ff;
   logic [SUM_W-1:0] quo_ff;
   logic [STEP_W-1:0] step_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_ff;

   logic cfg_hit, x_end, y_end, z_end;
   logic [XW-1:0] ax;
   logic [YW-1:0] ay;
   logic          aslot;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [ENTRY_W-1:0] rd_data;
   logic signed [DIFF_W-1:0] c19, l19, h19, d_in;
   logic signed [2*DIFF_W-1:0] prod;
   logic [CW:0]   shifted;
   logic [CW+1:0] trial;

   function automatic logic [AW-1:0] addr_of(input logic slot, input logic [XW-1:0] px,
                                             input logic [YW-1:0] py);
      addr_of = AW'(32'(slot) * 32'(PLANE) + 32'(py) * 32'(MAX_X) + 32'(px));
   endfunction

   // clamp written sizes into 1..MAX
   always_comb begin
      if (csr_wdata == '0) begin
         size_x_in = SXW'(1);
         size_y_in = SYW'(1);
         size_z_in = SZW'(1);
      end else begin
         size_x_in = (32'(csr_wdata) > 32'(MAX_X)) ? SXW'(MAX_X) : SXW'(csr_wdata);
         size_y_in = (32'(csr_wdata) > 32'(MAX_Y)) ? SYW'(MAX_Y) : SYW'(csr_wdata);
         size_z_in = (32'(csr_wdata) > 32'(MAX_Z)) ? SZW'(MAX_Z) : SZW'(csr_wdata);
      end
      cfg_hit = csr_we && ((csr_index == REG_SIZE_X) || (csr_index == REG_SIZE_Y) ||
                           (csr_index == REG_SIZE_Z));
   end

   // raster ends and interior flags
   assign x_end = (32'(x_ff) + 32'd1 >= 32'(size_x_ff));
   assign y_end = (32'(y_ff) + 32'd1 >= 32'(size_y_ff));
   assign z_end = (32'(z_ff) + 32'd1 >= 32'(size_z_ff));

   always_comb begin
      sts.axis_ok[0] = (32'(x_ff) >= 32'd2);
      sts.axis_ok[1] = (32'(y_ff) >= 32'd2);
      sts.axis_ok[2] = (32'(z_ff) >= 32'd2);
      sts.last       = x_end && y_end && z_end;
      sts.div_done   = (step_ff == STEP_W'(SUM_W - 1));
      sts.out_free   = !rsp_valid_ff || !rsp_stall;
   end

   // advance the raster position
   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      if (cfg_hit) begin
         x_in = '0;
         y_in = '0;
         z_in = '0;
      end else if (cmd.advance) begin
         if (!x_end) begin
            x_in = x_ff + XW'(1);
         end else begin
            x_in = '0;
            if (!y_end) begin
               y_in = y_ff + YW'(1);
            end else begin
               y_in = '0;
               z_in = z_end ? '0 : z_ff + ZW'(1);
            end
         end
      end
   end

   // neighbour address for the current axis
   always_comb begin
      ax    = x_ff;
      ay    = y_ff;
      aslot = z_ff[0];
      case (cmd.axis)
         AXIS_X:  ax = x_ff - (cmd.lo ? XW'(2) : XW'(1));
         AXIS_Y:  ay = y_ff - (cmd.lo ? YW'(2) : YW'(1));
         AXIS_Z:  aslot = cmd.lo ? z_ff[0] : ~z_ff[0];
         default: aslot = z_ff[0];
      endcase
      rd_addr = addr_of(aslot, ax, ay);
      wr_addr = addr_of(z_ff[0], x_ff, y_ff);
   end

   mle3d_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_plane (
      .clock   (clock),
      .wr_en   (cmd.write),
      .wr_addr (wr_addr),
      .wr_data (cur_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // second difference, zero when the centre is known
   always_comb begin
      c19  = {{(DIFF_W - SAMPLE_W){cent_ff[SAMPLE_W-1]}}, cent_ff[SAMPLE_W-1:0]};
      l19  = {{(DIFF_W - SAMPLE_W){lo_ff[SAMPLE_W-1]}}, lo_ff[SAMPLE_W-1:0]};
      h19  = {{(DIFF_W - SAMPLE_W){cur_ff[SAMPLE_W-1]}}, cur_ff[SAMPLE_W-1:0]};
      d_in = cent_ff[ENTRY_W-1] ? '0 : (c19 <<< 1) - l19 - h19;
      prod = d_ff * d_ff;
   end

   // one restoring divider step
   always_comb begin
      shifted = {rem_ff[CW-1:0], quo_ff[SUM_W-1]};
      trial   = {1'b0, shifted} - {2'b00, cnt_ff};
   end

   // accumulator
   always_comb begin
      acc_in = acc_ff;
      if (cfg_hit || cmd.out_load) begin
         acc_in = '0;
      end else if (cmd.add) begin
         acc_in = acc_ff + SUM_W'(sq_ff);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff    <= SXW'(1);
         size_y_ff    <= SYW'(1);
         size_z_ff    <= SZW'(1);
         x_ff         <= '0;
         y_ff         <= '0;
         z_ff         <= '0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we && (csr_index == REG_SIZE_X)) size_x_ff <= size_x_in;
         if (csr_we && (csr_index == REG_SIZE_Y)) size_y_ff <= size_y_in;
         if (csr_we && (csr_index == REG_SIZE_Z)) size_z_ff <= size_z_in;
         x_ff   <= x_in;
         y_ff   <= y_in;
         z_ff   <= z_in;
         acc_ff <= acc_in;
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.accept) cur_ff <= {req_data.known, req_data.sample};
      if (cmd.take_c) cent_ff <= rd_data;
      if (cmd.take_l) lo_ff <= rd_data;
      if (cmd.diff) d_ff <= d_in;
      if (cmd.square) sq_ff <= prod[SQ_W-1:0];
      if (cmd.cnt1) cnt_ff <= CW'(size_x_ff) * CW'(size_y_ff);
      if (cmd.cnt2) cnt_ff <= CW'(cnt_ff[SXW+SYW-1:0]) * CW'(size_z_ff);
      if (cmd.div_start) begin
         rem_ff  <= '0;
         quo_ff  <= acc_ff;
         step_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff  <= trial[CW+1] ? shifted : trial[CW:0];
         quo_ff  <= {quo_ff[SUM_W-2:0], ~trial[CW+1]};
         step_ff <= step_ff + STEP_W'(1);
      end
      if (cmd.out_load) begin
         rsp_ff.energy_sum  <= acc_ff;
         rsp_ff.energy_mean <= quo_ff[MEAN_W-1:0];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> verif/tb_masked_laplacian_energy_3d_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_masked_laplacian_energy_3d_unit
// Streams volumes of voxels through the unit under several size settings.
// A local energy predictor computes each volume's sum and mean, and every
// returned word is checked against it. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_masked_laplacian_energy_3d_unit;
   import mle3d_pkg::*;

   localparam int                SIDE       = 256;
   localparam int                WATCH_LIM  = 5000;
   localparam int                SETTLE     = 200;
   localparam logic [CSR_IW-1:0] REG_UNUSED = 2'd3;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   req_type           req_data  = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   rsp_type           rsp_data;
   logic              csr_we    = 1'b0;
   logic [CSR_IW-1:0] csr_index = '0;
   logic [CSR_W-1:0]  csr_wdata = '0;

   masked_laplacian_energy_3d_unit dut (.*);

   // predictor state
   logic [16:0]  plane_buf [0:2*SIDE*SIDE-1];
   int unsigned  dim_x = 1, dim_y = 1, dim_z = 1;
   int unsigned  at_x = 0, at_y = 0, at_z = 0;
   logic [63:0]  energy_run = '0;

   req_type      voxel_q  [$];
   rsp_type      energy_q [$];
   logic         voxel_taken = 1'b0;
   bit           quiet_phase = 0;
   int           req_gap = 0, rsp_gap = 0;
   int           fail_count = 0, idle_cycles = 0;
   int           voxels_sent = 0, volumes_seen = 0, random_voxels = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      if (quiet_phase) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic int unsigned clamp_dim(logic [CSR_W-1:0] v);
      if (v == 0) return 1;
      if (v > SIDE) return SIDE;
      return v;
   endfunction

   // squared second difference of one axis, zero for a masked centre
   function automatic logic [63:0] axis_energy(logic [16:0] mid, logic [16:0] lo,
                                               logic signed [15:0] hi);
      longint d;
      if (mid[16]) return 64'd0;
      d = 2 * longint'($signed(mid[15:0])) - longint'($signed(lo[15:0]))
          - longint'(hi);
      return d * d;
   endfunction

   // advance the predictor by one voxel; push the result at volume end
   function automatic void predict_voxel(req_type v);
      int unsigned slot, base, other;
      logic [63:0] add, cnt;
      rsp_type     res;
      slot  = at_z & 1;
      base  = slot * SIDE * SIDE;
      other = (slot ^ 1) * SIDE * SIDE;
      add   = 0;
      if (at_x >= 2)
         add += axis_energy(plane_buf[base + at_y*SIDE + at_x - 1],
                            plane_buf[base + at_y*SIDE + at_x - 2], v.sample);
      if (at_y >= 2)
         add += axis_energy(plane_buf[base + (at_y-1)*SIDE + at_x],
                            plane_buf[base + (at_y-2)*SIDE + at_x], v.sample);
      if (at_z >= 2)
         add += axis_energy(plane_buf[other + at_y*SIDE + at_x],
                            plane_buf[base + at_y*SIDE + at_x], v.sample);
      plane_buf[base + at_y*SIDE + at_x] = {v.known, v.sample};
      energy_run = (energy_run + add) & ((64'd1 << SUM_W) - 1);
      if (at_x + 1 < dim_x) begin
         at_x++;
         return;
      end
      at_x = 0;
      if (at_y + 1 < dim_y) begin
         at_y++;
         return;
      end
      at_y = 0;
      if (at_z + 1 < dim_z) begin
         at_z++;
         return;
      end
      at_z = 0;
      cnt = 64'(dim_x) * 64'(dim_y) * 64'(dim_z);
      res.energy_sum  = energy_run[SUM_W-1:0];
      res.energy_mean = MEAN_W'(energy_run / cnt);
      energy_q.push_back(res);
      energy_run = 0;
   endfunction

   // input side: accept tracking, prediction, result check, watchdog
   always @(posedge clock) begin
      voxel_taken <= req_valid && !req_stall && !reset;
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (req_valid && !req_stall) begin
            predict_voxel(req_data);
         end
         if (rsp_valid && !rsp_stall) begin
            volumes_seen <= volumes_seen + 1;
            if (energy_q.size() == 0) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10)
                  $display("unexpected result word sum=%0d mean=%0d",
                           rsp_data.energy_sum, rsp_data.energy_mean);
            end else begin
               if (rsp_data !== energy_q[0]) begin
                  fail_count <= fail_count + 1;
                  if (fail_count < 10)
                     $display("mismatch: sum exp %0d got %0d, mean exp %0d got %0d",
                              energy_q[0].energy_sum, rsp_data.energy_sum,
                              energy_q[0].energy_mean, rsp_data.energy_mean);
               end
               void'(energy_q.pop_front());
            end
         end
         if (idle_cycles >= WATCH_LIM) begin
            $display("watchdog: no word moved for %0d cycles", WATCH_LIM);
            $display("tb_masked_laplacian_energy_3d_unit: FAIL");
            $finish;
         end
      end
   end

   // voxel driver: hold until taken, then idle or load the next word
   always @(negedge clock) begin
      if (!reset && (!req_valid || voxel_taken)) begin
         if (req_gap > 0) begin
            req_gap   <= req_gap - 1;
            req_valid <= 1'b0;
         end else if (voxel_q.size() != 0) begin
            req_data  <= voxel_q.pop_front();
            req_valid <= 1'b1;
            req_gap   <= pick_gap();
            voxels_sent <= voxels_sent + 1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result stall generator
   always @(negedge clock) begin
      if (rsp_gap > 0) begin
         rsp_gap   <= rsp_gap - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         rsp_gap   <= pick_gap();
      end
   end

   // one register write; the predictor follows at the same time
   task automatic write_reg(logic [CSR_IW-1:0] idx, logic [CSR_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         REG_SIZE_X: dim_x = clamp_dim(val);
         REG_SIZE_Y: dim_y = clamp_dim(val);
         REG_SIZE_Z: dim_z = clamp_dim(val);
         default: return;
      endcase
      at_x = 0;
      at_y = 0;
      at_z = 0;
      energy_run = 0;
   endtask

   task automatic set_sizes(logic [CSR_W-1:0] sx, logic [CSR_W-1:0] sy,
                            logic [CSR_W-1:0] sz);
      write_reg(REG_SIZE_X, sx);
      write_reg(REG_SIZE_Y, sy);
      write_reg(REG_SIZE_Z, sz);
      if ($urandom_range(0, 2) == 0)
         write_reg(REG_UNUSED, CSR_W'($urandom));
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // wait for all words to move, then let the last volume settle
   task automatic drain();
      while (voxel_q.size() != 0 || req_valid || energy_q.size() != 0)
         @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   function automatic req_type rand_voxel();
      req_type v;
      int r;
      r = $urandom_range(0, 9);
      if (r < 2)
         v.sample = r[0] ? 16'sh7fff : 16'sh8000;
      else if (r < 5)
         v.sample = 16'($signed($urandom_range(0, 64)) - 32);
      else
         v.sample = 16'($urandom);
      v.known = ($urandom_range(0, 3) == 0);
      return v;
   endfunction

   // queue whole volumes; style 1 alternates the sample extremes
   task automatic queue_volumes(int nvol, int style);
      req_type v;
      int n;
      n = nvol * dim_x * dim_y * dim_z;
      for (int i = 0; i < n; i++) begin
         if (style == 1) begin
            v.sample = i[0] ? 16'sh7fff : 16'sh8000;
            v.known  = 1'b0;
         end else begin
            v = rand_voxel();
         end
         voxel_q.push_back(v);
      end
   endtask

   initial begin
      req_type v;
      int sx, sy, sz, nv;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset sizes: every voxel closes a one-voxel volume
      v = '{sample: 16'sh7fff, known: 1'b0};  voxel_q.push_back(v);
      v = '{sample: 16'sh8000, known: 1'b1};  voxel_q.push_back(v);
      v = '{sample: 16'sh0000, known: 1'b0};  voxel_q.push_back(v);
      drain();

      // worst-case differences along each axis alone, then all three
      set_sizes(9'd3, 9'd0, 9'd1);
      queue_volumes(1, 1);
      drain();
      set_sizes(9'd1, 9'd3, 9'd1);
      queue_volumes(1, 1);
      drain();
      set_sizes(9'd1, 9'd1, 9'd3);
      queue_volumes(1, 1);
      drain();
      set_sizes(9'd3, 9'd3, 9'd3);
      queue_volumes(1, 1);
      drain();

      // short axes, the clamped maximum on x and long y and z axes
      set_sizes(9'd2, 9'd2, 9'd2);
      queue_volumes(2, 0);
      drain();
      set_sizes(9'h1ff, 9'd1, 9'd1);
      queue_volumes(1, 0);
      drain();
      set_sizes(9'd1, 9'd20, 9'd1);
      queue_volumes(1, 0);
      drain();
      set_sizes(9'd0, 9'd1, 9'd20);
      queue_volumes(1, 0);
      drain();

      // random sizes and content, with a partial volume cut by a write
      while (random_voxels < 250) begin
         quiet_phase = ($urandom_range(0, 4) == 0);
         sx = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 20) : $urandom_range(0, 6);
         sy = $urandom_range(0, 5);
         sz = $urandom_range(0, 5);
         set_sizes(9'(sx), 9'(sy), 9'(sz));
         nv = $urandom_range(1, 3);
         queue_volumes(nv, 0);
         random_voxels += nv * dim_x * dim_y * dim_z;
         if ($urandom_range(0, 5) == 0 && dim_x * dim_y * dim_z > 1)
            voxel_q.push_back(rand_voxel());
         drain();
      end
      quiet_phase = 0;

      $display("run covered %0d voxels and %0d volume results", voxels_sent,
               volumes_seen);
      $display("size settings from 1 to clamped 256 on x; %0d mismatches",
               fail_count);
      if (fail_count == 0)
         $display("tb_masked_laplacian_energy_3d_unit: PASS");
      else
         $display("tb_masked_laplacian_energy_3d_unit: FAIL");
      $finish;
   end

endmodule
